>>> rtl/gmhp_pkg.sv
`timescale 1ns / 1ps

package gmhp_pkg;

    localparam logic [7:0]  MAGIC_0      = 8'h1f;
    localparam logic [7:0]  MAGIC_1      = 8'h8b;
    localparam logic [7:0]  METHOD_DEFL  = 8'h08;
    localparam int unsigned FLG_FHCRC    = 1;
    localparam int unsigned FLG_FEXTRA   = 2;
    localparam int unsigned FLG_FNAME    = 3;
    localparam int unsigned FLG_FCOMMENT = 4;
    localparam logic [32:0] MIN_LENGTH   = 33'd18;
    localparam logic [32:0] FOOTER_LEN   = 33'd8;
    localparam logic [15:0] FIXED_SKIP   = 16'd6;
    localparam logic [15:0] HCRC_SKIP    = 16'd2;

    // option flag bits as kept internally
    localparam int unsigned OPT_EXTRA   = 0;
    localparam int unsigned OPT_NAME    = 1;
    localparam int unsigned OPT_COMMENT = 2;
    localparam int unsigned OPT_HCRC    = 3;

    typedef enum logic [3:0] {
        PH_MAGIC0  = 4'd0,
        PH_MAGIC1  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_FIXED   = 4'd4,
        PH_XLEN_LO = 4'd5,
        PH_XLEN_HI = 4'd6,
        PH_XDATA   = 4'd7,
        PH_NAME    = 4'd8,
        PH_COMMENT = 4'd9,
        PH_HCRC    = 4'd10,
        PH_BODY    = 4'd11,
        PH_FAIL    = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        CLS_HEADER  = 2'd0,
        CLS_PAYLOAD = 2'd1,
        CLS_FOOTER  = 2'd2,
        CLS_ERROR   = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_TOO_SHORT    = 3'd1,
        ERR_BAD_MAGIC    = 3'd2,
        ERR_BAD_METHOD   = 3'd3,
        ERR_INTO_FOOTER  = 3'd4,
        ERR_ENDED_HEADER = 3'd5
    } t_err;

    typedef struct packed {
        t_class      byte_class;
        t_err        error_code;
        logic [7:0]  payload_byte;
        logic [31:0] byte_offset;
        logic [31:0] body_offset;
        logic [31:0] isize;
        logic        isize_valid;
    } t_result;

    // next header phase, walking the optional fields in RFC order
    function automatic t_phase next_phase(input logic [3:0] flags, input t_phase after);
        t_phase ph;
        if (after < PH_XLEN_LO && flags[OPT_EXTRA]) begin
            ph = PH_XLEN_LO;
        end else if (after < PH_NAME && flags[OPT_NAME]) begin
            ph = PH_NAME;
        end else if (after < PH_COMMENT && flags[OPT_COMMENT]) begin
            ph = PH_COMMENT;
        end else if (after < PH_HCRC && flags[OPT_HCRC]) begin
            ph = PH_HCRC;
        end else begin
            ph = PH_BODY;
        end
        return ph;
    endfunction

endpackage

>>> rtl/gmhp_parse_core.sv
`timescale 1ns / 1ps

module gmhp_parse_core
    import gmhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_total_length,
    output t_result     o_result
);

    t_phase      r_phase, n_phase, e_phase;
    logic [31:0] r_pos, n_pos, e_pos;
    logic [3:0]  r_flags, n_flags, e_flags;
    logic [15:0] r_skip, n_skip, e_skip;
    logic [31:0] r_isize, n_isize, e_isize;
    t_err        r_err, n_err, e_err;
    logic [31:0] r_start, n_start, e_start;

    t_err        err;
    logic        header;
    logic [15:0] skip_dec;
    logic [15:0] xlen;
    logic [32:0] pos_w;
    logic [32:0] len_w;
    t_class      cls;

    always_comb begin
        // first_byte restarts the parse from the reset state
        e_phase = i_first_byte ? PH_MAGIC0 : r_phase;
        e_pos   = i_first_byte ? '0 : r_pos;
        e_flags = i_first_byte ? '0 : r_flags;
        e_skip  = i_first_byte ? '0 : r_skip;
        e_isize = i_first_byte ? '0 : r_isize;
        e_err   = i_first_byte ? ERR_NONE : r_err;
        e_start = i_first_byte ? '0 : r_start;

        pos_w    = {1'b0, e_pos};
        len_w    = {1'b0, i_total_length};
        skip_dec = e_skip - 16'd1;
        xlen     = e_skip | {i_data_byte, 8'h00};

        n_phase = e_phase;
        n_flags = e_flags;
        n_skip  = e_skip;
        n_err   = e_err;
        n_start = e_start;
        err     = ERR_NONE;
        header  = 1'b0;

        if (e_err == ERR_NONE) begin
            header = 1'b1;
            case (e_phase)
                PH_MAGIC0: begin
                    if (len_w < MIN_LENGTH) begin
                        err = ERR_TOO_SHORT;
                    end else if (i_data_byte != MAGIC_0) begin
                        err = ERR_BAD_MAGIC;
                    end else begin
                        n_phase = PH_MAGIC1;
                    end
                end
                PH_MAGIC1: begin
                    if (i_data_byte != MAGIC_1) begin
                        err = ERR_BAD_MAGIC;
                    end else begin
                        n_phase = PH_METHOD;
                    end
                end
                PH_METHOD: begin
                    if (i_data_byte != METHOD_DEFL) begin
                        err = ERR_BAD_METHOD;
                    end else begin
                        n_phase = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    n_flags[OPT_EXTRA]   = i_data_byte[FLG_FEXTRA];
                    n_flags[OPT_NAME]    = i_data_byte[FLG_FNAME];
                    n_flags[OPT_COMMENT] = i_data_byte[FLG_FCOMMENT];
                    n_flags[OPT_HCRC]    = i_data_byte[FLG_FHCRC];
                    n_skip  = FIXED_SKIP;
                    n_phase = PH_FIXED;
                end
                PH_FIXED: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = next_phase(e_flags, PH_FIXED);
                    end
                end
                PH_XLEN_LO: begin
                    n_skip  = {8'h00, i_data_byte};
                    n_phase = PH_XLEN_HI;
                end
                PH_XLEN_HI: begin
                    n_skip  = xlen;
                    n_phase = (xlen == '0) ? next_phase(e_flags, PH_XDATA) : PH_XDATA;
                end
                PH_XDATA: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = next_phase(e_flags, PH_XDATA);
                    end
                end
                PH_NAME: begin
                    if (i_data_byte == 8'h00) begin
                        n_phase = next_phase(e_flags, PH_NAME);
                    end
                end
                PH_COMMENT: begin
                    if (i_data_byte == 8'h00) begin
                        n_phase = next_phase(e_flags, PH_COMMENT);
                    end
                end
                PH_HCRC: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = PH_BODY;
                    end
                end
                default: begin
                    header = 1'b0;
                end
            endcase

            // entering the CRC field loads its two-byte count
            if (n_phase == PH_HCRC && e_phase != PH_HCRC) begin
                n_skip = HCRC_SKIP;
            end

            if (header && err == ERR_NONE) begin
                if (pos_w + FOOTER_LEN + 33'd1 >= len_w) begin
                    err = ERR_INTO_FOOTER;
                end else if (n_phase == PH_BODY) begin
                    n_start = e_pos + 32'd1;
                end else if (i_last_byte) begin
                    err = ERR_ENDED_HEADER;
                end
            end

            if (err != ERR_NONE) begin
                n_err   = err;
                n_phase = PH_FAIL;
            end
        end

        n_isize = {i_data_byte, e_isize[31:8]};
        n_pos   = e_pos + 32'd1;

        if (n_err != ERR_NONE) begin
            cls = CLS_ERROR;
        end else if (header) begin
            cls = CLS_HEADER;
        end else if (pos_w + FOOTER_LEN >= len_w) begin
            cls = CLS_FOOTER;
        end else begin
            cls = CLS_PAYLOAD;
        end

        o_result.byte_class   = cls;
        o_result.error_code   = n_err;
        o_result.payload_byte = i_data_byte;
        o_result.byte_offset  = e_pos;
        o_result.body_offset  = n_start;
        o_result.isize        = n_isize;
        o_result.isize_valid  = i_last_byte && (n_err == ERR_NONE)
                                && (pos_w + 33'd1 == len_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC0;
            r_pos   <= '0;
            r_flags <= '0;
            r_skip  <= '0;
            r_isize <= '0;
            r_err   <= ERR_NONE;
            r_start <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_skip  <= n_skip;
            r_isize <= n_isize;
            r_err   <= n_err;
            r_start <= n_start;
        end
    end

    // a latched error parks the parser in the fail phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> (r_phase == PH_FAIL))
        else $error("error latched outside fail phase");

endmodule

>>> rtl/gmhp_out_stage.sv
`timescale 1ns / 1ps

module gmhp_out_stage
    import gmhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_space,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // a waiting item is replaced in the same cycle it is taken
    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> rtl/gzip_member_header_parser.sv
`timescale 1ns / 1ps

// gzip member header parser, one file byte per item.
// Input channel (i_in_valid / o_in_ready) carries data_byte with first_byte
// and last_byte marks; first_byte restarts the parse at offset 0.
// Output channel (o_out_valid / i_out_ready) returns one item per input:
// class (header, payload, footer, error), sticky error code, the byte itself,
// its offset, the deflate start offset and the running little-endian ISIZE.
// Config channel (i_cfg_valid / o_cfg_ready) writes total_length; it is
// always ready and should be written only while the block is idle.
// The result is registered and shows the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls; parse state and
// output register both update at the accepting edge, so back-to-back items
// flow freely. When the receiver stalls, the finished item waits in the
// output register and the input side stalls too; o_in_ready returns the same
// cycle the output is taken. Reset (synchronous, active low) empties the output
// and starts the parse as if the next byte were a first byte; total_length = 0.

module gzip_member_header_parser
    import gmhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_total_length,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_byte_class,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_byte_offset,
    output logic [31:0] o_body_offset,
    output logic [31:0] o_isize,
    output logic        o_isize_valid
);

    logic [31:0] r_total_length;
    logic        space;
    logic        accept;
    t_result     core_result;
    t_result     out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= '0;
        end else if (i_cfg_valid) begin
            r_total_length <= i_cfg_total_length;
        end
    end

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    gmhp_parse_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_total_length (r_total_length),
        .o_result       (core_result)
    );

    gmhp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (core_result),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_byte_class   = out_result.byte_class;
    assign o_error_code   = out_result.error_code;
    assign o_payload_byte = out_result.payload_byte;
    assign o_byte_offset  = out_result.byte_offset;
    assign o_body_offset  = out_result.body_offset;
    assign o_isize        = out_result.isize;
    assign o_isize_valid  = out_result.isize_valid;

    // every accepted item shows up on the output the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item missing from output");

    // class and error code agree
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_byte_class == CLS_ERROR) == (o_error_code != ERR_NONE)))
        else $error("byte class and error code disagree");

    // ISIZE is only flagged good on an error-free last byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_isize_valid) |-> (o_error_code == ERR_NONE))
        else $error("isize flagged valid with an error");

    // offsets of consecutive items of one file step by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_first_byte) |=>
            (o_byte_offset == $past(u_core.r_pos)))
        else $error("byte offset out of sequence");

endmodule

>>> dv/tb_gzip_member_header_parser.sv
`timescale 1ns / 1ps

module tb_gzip_member_header_parser
    import gmhp_pkg::*;
();

    // Run guard; the slowest legal run (heavy idling, many drains) is far below this.
    localparam int unsigned CYCLE_LIMIT = 600000;

    // ------------------------------------------------------------------
    // DUT-facing signals, the driven inputs all known from time zero
    // ------------------------------------------------------------------
    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_cfg_valid        = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_total_length = '0;
    logic        i_in_valid         = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte        = '0;
    logic        i_first_byte       = 1'b0;
    logic        i_last_byte        = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready        = 1'b0;
    logic [1:0]  o_byte_class;
    logic [2:0]  o_error_code;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_byte_offset;
    logic [31:0] o_body_offset;
    logic [31:0] o_isize;
    logic        o_isize_valid;

    gzip_member_header_parser DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_total_length (i_cfg_total_length),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_first_byte       (i_first_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_byte_class       (o_byte_class),
        .o_error_code       (o_error_code),
        .o_payload_byte     (o_payload_byte),
        .o_byte_offset      (o_byte_offset),
        .o_body_offset      (o_body_offset),
        .o_isize            (o_isize),
        .o_isize_valid      (o_isize_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    t_result     byte_reports_q[$];     // expected per-byte reports, oldest first
    logic [7:0]  gz_bytes[$];           // member currently being streamed
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          items_sent         = 0;
    int          members_sent       = 0;
    int          results_seen       = 0;
    int          mismatch_count     = 0;
    int          code_hits[8];
    int unsigned cycle_count        = 0;

    // ------------------------------------------------------------------
    // Header parse tracker: mirrors the block's state byte by byte
    // ------------------------------------------------------------------
    t_phase      ph_state;
    logic [31:0] at_pos;
    logic [3:0]  opt_sel;       // indexed by OPT_EXTRA / OPT_NAME / OPT_COMMENT / OPT_HCRC
    logic [15:0] skip_left;
    logic [31:0] isize_shift;
    t_err        err_held;
    logic [31:0] body_start;
    logic [31:0] file_len;      // shadow of total_length

    function automatic void restart_parse();
        ph_state    = PH_MAGIC0;
        at_pos      = '0;
        opt_sel     = '0;
        skip_left   = '0;
        isize_shift = '0;
        err_held    = ERR_NONE;
        body_start  = '0;
    endfunction

    // Which optional field follows the one just finished (RFC order).
    // Entering the header CRC also loads its two-byte count.
    function automatic t_phase following_field(input t_phase done);
        if (done < PH_XLEN_LO && opt_sel[OPT_EXTRA]) return PH_XLEN_LO;
        if (done < PH_NAME && opt_sel[OPT_NAME]) return PH_NAME;
        if (done < PH_COMMENT && opt_sel[OPT_COMMENT]) return PH_COMMENT;
        if (done < PH_HCRC && opt_sel[OPT_HCRC]) begin
            skip_left = HCRC_SKIP;
            return PH_HCRC;
        end
        return PH_BODY;
    endfunction

    // Advance the tracker by one accepted byte and return its report.
    function automatic t_result classify_byte(input logic [7:0] b, input logic first_mark,
                                              input logic last_mark);
        t_result     r;
        t_err        e;
        logic        in_header;
        logic [32:0] pos_w;
        logic [32:0] len_w;
        if (first_mark) restart_parse();
        pos_w     = {1'b0, at_pos};
        len_w     = {1'b0, file_len};
        e         = ERR_NONE;
        in_header = 1'b0;
        if (err_held == ERR_NONE) begin
            in_header = 1'b1;
            case (ph_state)
                PH_MAGIC0: begin
                    if (len_w < MIN_LENGTH) e = ERR_TOO_SHORT;
                    else if (b != MAGIC_0) e = ERR_BAD_MAGIC;
                    else ph_state = PH_MAGIC1;
                end
                PH_MAGIC1: begin
                    if (b != MAGIC_1) e = ERR_BAD_MAGIC;
                    else ph_state = PH_METHOD;
                end
                PH_METHOD: begin
                    if (b != METHOD_DEFL) e = ERR_BAD_METHOD;
                    else ph_state = PH_FLAGS;
                end
                PH_FLAGS: begin
                    // FTEXT and reserved bits are don't-care
                    opt_sel[OPT_EXTRA]   = b[FLG_FEXTRA];
                    opt_sel[OPT_NAME]    = b[FLG_FNAME];
                    opt_sel[OPT_COMMENT] = b[FLG_FCOMMENT];
                    opt_sel[OPT_HCRC]    = b[FLG_FHCRC];
                    skip_left = FIXED_SKIP;
                    ph_state  = PH_FIXED;
                end
                PH_FIXED: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 0) ph_state = following_field(PH_FIXED);
                end
                PH_XLEN_LO: begin
                    skip_left = {8'h00, b};
                    ph_state  = PH_XLEN_HI;
                end
                PH_XLEN_HI: begin
                    skip_left = {b, skip_left[7:0]};
                    ph_state  = (skip_left == 0) ? following_field(PH_XDATA) : PH_XDATA;
                end
                PH_XDATA: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 0) ph_state = following_field(PH_XDATA);
                end
                PH_NAME: begin
                    if (b == 8'h00) ph_state = following_field(PH_NAME);
                end
                PH_COMMENT: begin
                    if (b == 8'h00) ph_state = following_field(PH_COMMENT);
                end
                PH_HCRC: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 0) ph_state = PH_BODY;
                end
                default: begin
                    in_header = 1'b0;
                end
            endcase
            if (in_header && e == ERR_NONE) begin
                // header must end before the 8-byte trailer starts
                if (pos_w + 33'd1 + FOOTER_LEN >= len_w) e = ERR_INTO_FOOTER;
                else if (ph_state == PH_BODY) body_start = at_pos + 32'd1;
                else if (last_mark) e = ERR_ENDED_HEADER;
            end
            if (e != ERR_NONE) begin
                err_held = e;
                ph_state = PH_FAIL;
                code_hits[e]++;
            end
        end

        isize_shift = {b, isize_shift[31:8]};

        if (err_held != ERR_NONE) r.byte_class = CLS_ERROR;
        else if (in_header) r.byte_class = CLS_HEADER;
        else if (pos_w + FOOTER_LEN >= len_w) r.byte_class = CLS_FOOTER;
        else r.byte_class = CLS_PAYLOAD;

        r.error_code   = err_held;
        r.payload_byte = b;
        r.byte_offset  = at_pos;
        r.body_offset  = body_start;
        r.isize        = isize_shift;
        r.isize_valid  = last_mark && err_held == ERR_NONE && pos_w + 33'd1 == len_w;

        at_pos = at_pos + 32'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus in-order field compare
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string diff, input t_result exp, input t_result act);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch:%s", $realtime, diff);
            $display("  exp cls %0d err %0d byte %02h off %0d dfl %0d isz %08h iv %0b",
                     exp.byte_class, exp.error_code, exp.payload_byte, exp.byte_offset,
                     exp.body_offset, exp.isize, exp.isize_valid);
            $display("  got cls %0d err %0d byte %02h off %0d dfl %0d isz %08h iv %0b",
                     act.byte_class, act.error_code, act.payload_byte, act.byte_offset,
                     act.body_offset, act.isize, act.isize_valid);
        end
    endtask

    task automatic compare_report(input t_result act);
        t_result exp;
        string   diff;
        results_seen++;
        if (byte_reports_q.size() == 0) begin
            flag_mismatch(" output item with nothing pending", '0, act);
        end else begin
            exp  = byte_reports_q.pop_front();
            diff = "";
            if (act.byte_class !== exp.byte_class) diff = {diff, " class"};
            if (act.error_code !== exp.error_code) diff = {diff, " error_code"};
            if (act.payload_byte !== exp.payload_byte) diff = {diff, " payload_byte"};
            if (act.byte_offset !== exp.byte_offset) diff = {diff, " byte_offset"};
            if (act.body_offset !== exp.body_offset) diff = {diff, " body_offset"};
            if (act.isize !== exp.isize) diff = {diff, " isize"};
            if (act.isize_valid !== exp.isize_valid) diff = {diff, " isize_valid"};
            if (diff != "") flag_mismatch(diff, exp, act);
        end
    endtask

    // Sample the pre-edge handshake, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            compare_report(t_result'({o_byte_class, o_error_code, o_payload_byte,
                                      o_byte_offset, o_body_offset, o_isize,
                                      o_isize_valid}));
        end
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One byte item. Valid is only dropped when a gap is taken, so a
    // back-to-back item never sees two assignments to valid in one step.
    task automatic send_byte(input logic [7:0] b, input logic first_mark,
                             input logic last_mark);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= first_mark;
        i_last_byte  <= last_mark;
        do @(posedge i_clk); while (!o_in_ready);
        byte_reports_q.push_back(classify_byte(b, first_mark, last_mark));
        items_sent++;
    endtask

    // Stop feeding, wait for every pending report, then let the clock run on
    // so the block is fully quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (byte_reports_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Only called right after settle(), i.e. with the block idle.
    task automatic write_length(input logic [31:0] len);
        i_cfg_valid        <= 1'b1;
        i_cfg_total_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        file_len = len;
    endtask

    // Assemble a well-formed member into gz_bytes.
    task automatic build_member(input logic [7:0] flg, input int xlen, input int name_len,
                                input int comment_len, input int body_len);
        gz_bytes.delete();
        gz_bytes.push_back(MAGIC_0);
        gz_bytes.push_back(MAGIC_1);
        gz_bytes.push_back(METHOD_DEFL);
        gz_bytes.push_back(flg);
        repeat (6) gz_bytes.push_back(8'($urandom_range(255)));   // MTIME, XFL, OS
        if (flg[FLG_FEXTRA]) begin
            gz_bytes.push_back(8'(xlen));
            gz_bytes.push_back(8'(xlen >> 8));
            repeat (xlen) gz_bytes.push_back(8'($urandom_range(255)));
        end
        if (flg[FLG_FNAME]) begin
            repeat (name_len) gz_bytes.push_back(8'($urandom_range(255, 1)));
            gz_bytes.push_back(8'h00);
        end
        if (flg[FLG_FCOMMENT]) begin
            repeat (comment_len) gz_bytes.push_back(8'($urandom_range(255, 1)));
            gz_bytes.push_back(8'h00);
        end
        if (flg[FLG_FHCRC]) repeat (2) gz_bytes.push_back(8'($urandom_range(255)));
        repeat (body_len) gz_bytes.push_back(8'($urandom_range(255)));
        repeat (8) gz_bytes.push_back(8'($urandom_range(255)));   // CRC32 + ISIZE
    endtask

    // Stream gz_bytes. Optionally rewrites total_length first, and once more
    // partway through (at mid_idx) after draining.
    task automatic stream_member(input logic [31:0] len, input bit write_len,
                                 input bit mark_first, input int last_idx,
                                 input int mid_idx, input logic [31:0] mid_len);
        if (write_len) begin
            settle();
            write_length(len);
        end
        for (int i = 0; i < gz_bytes.size(); i++) begin
            if (i == mid_idx) begin
                settle();
                write_length(mid_len);
            end
            send_byte(gz_bytes[i], mark_first && i == 0, i == last_idx);
        end
        members_sent++;
    endtask

    task automatic stream_prefix(input logic [31:0] len, input int keep);
        gz_bytes = gz_bytes[0:keep-1];
        stream_member(len, 1'b1, 1'b1, keep - 1, -1, '0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Right after reset, no first_byte mark: parse must still start at offset 0.
    // Every flag bit set, so all optional fields plus FTEXT/reserved bits.
    task automatic test_all_options_after_reset();
        build_member(8'hff, 2, 2, 1, 2);
        stream_member(gz_bytes.size(), 1'b1, 1'b0, gz_bytes.size() - 1, -1, '0);
    endtask

    // total_length at 0, 17, all-ones, and the 18-byte minimum (which cannot
    // hold a header and trailer with room for a body).
    task automatic test_length_extremes();
        build_member(8'h00, 0, 0, 0, 1);
        stream_prefix(32'd0, 3);
        build_member(8'h00, 0, 0, 0, 1);
        stream_prefix(MIN_LENGTH[31:0] - 32'd1, 3);
        build_member(8'h00, 0, 0, 0, 1);
        stream_prefix(32'hffff_ffff, 4);
        build_member(8'h00, 0, 0, 0, 0);
        stream_member(gz_bytes.size(), 1'b1, 1'b1, gz_bytes.size() - 1, -1, '0);
    endtask

    task automatic test_bad_magic_and_method();
        build_member(8'h00, 0, 0, 0, 2);
        gz_bytes[0] = 8'h1e;
        stream_prefix(gz_bytes.size(), 3);
        build_member(8'h00, 0, 0, 0, 2);
        gz_bytes[1] = 8'h0b;
        stream_prefix(gz_bytes.size(), 3);
        build_member(8'h00, 0, 0, 0, 2);
        gz_bytes[2] = 8'h88;
        stream_prefix(gz_bytes.size(), 4);
    endtask

    task automatic test_header_boundaries();
        // last_byte in the middle of the fixed fields
        build_member(8'h00, 0, 0, 0, 2);
        stream_member(32'd100, 1'b1, 1'b1, 5, -1, '0);
        // last_byte on the byte that closes the header is legal; the bytes
        // after it just keep flowing through the parse
        build_member(8'h00, 0, 0, 0, 2);
        stream_member(32'd100, 1'b1, 1'b1, 9, -1, '0);
    endtask

    // One idling mix: mostly well-formed members with random content, the
    // rest corrupted, truncated, mislabeled or plain noise.
    task automatic random_member();
        logic [7:0]  flg;
        logic [31:0] len;
        logic [31:0] mid_len;
        int          last_idx;
        int          mid_idx;
        bit          write_len;
        bit          mark_first;
        flg = 8'($urandom_range(255));
        build_member(flg, $urandom_range(3), $urandom_range(4), $urandom_range(4),
                     $urandom_range(10));
        len        = gz_bytes.size();
        last_idx   = gz_bytes.size() - 1;
        mid_idx    = -1;
        mid_len    = '0;
        mark_first = 1'b1;
        write_len  = ($urandom_range(3) != 0);   // else reuse the current length
        if ($urandom_range(99) >= 65) begin
            case ($urandom_range(7))
                0: gz_bytes[$urandom_range(last_idx)] = 8'($urandom_range(255));
                1: len = len + $urandom_range(12) - 6;
                2: begin
                    case ($urandom_range(3))
                        0: len = '0;
                        1: len = MIN_LENGTH[31:0] - 32'd1;
                        2: len = '1;
                        default: len = $urandom();
                    endcase
                end
                3: begin
                    last_idx = $urandom_range(last_idx);
                    len      = last_idx + 1;
                    if ($urandom_range(1)) gz_bytes = gz_bytes[0:last_idx];
                end
                4: mark_first = 1'b0;
                5: begin
                    // wild extra-field length (can run deep into the trailer), else random flags
                    if (flg[FLG_FEXTRA]) begin
                        gz_bytes[10] = 8'($urandom_range(255));
                        gz_bytes[11] = 8'($urandom_range(255));
                    end else begin
                        gz_bytes[3] = 8'($urandom_range(255));
                    end
                end
                6: begin
                    mid_idx = $urandom_range(last_idx, 1);
                    mid_len = len + $urandom_range(8) - 4;
                end
                default: begin
                    gz_bytes.delete();
                    repeat ($urandom_range(30, 1)) gz_bytes.push_back(8'($urandom_range(255)));
                    last_idx = $urandom_range(gz_bytes.size() - 1);
                end
            endcase
        end
        stream_member(len, write_len, mark_first, last_idx, mid_idx, mid_len);
    endtask

    task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                      input int item_count);
        int target;
        target             = items_sent + item_count;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        while (items_sent < target) random_member();
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        file_len = '0;
        restart_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_all_options_after_reset();
        test_length_extremes();
        test_bad_magic_and_method();
        test_header_boundaries();

        test_random_stream(0, 0, 100);
        test_random_stream(77, 0, 100);
        test_random_stream(0, 77, 100);
        test_random_stream(26, 26, 100);

        settle();
        $display("Streamed %0d bytes in %0d members over four idle/stall mixes; %0d compared.",
                 items_sent, members_sent, results_seen);
        $display("Latched errors: short %0d, magic %0d, method %0d, into trailer %0d, %s %0d",
                 code_hits[ERR_TOO_SHORT], code_hits[ERR_BAD_MAGIC], code_hits[ERR_BAD_METHOD],
                 code_hits[ERR_INTO_FOOTER], "cut in header", code_hits[ERR_ENDED_HEADER]);
        if (mismatch_count == 0 && byte_reports_q.size() == 0) begin
            $display("** gzip_member_header_parser: PASSED **");
        end else begin
            $display("%0d mismatches, %0d reports never arrived", mismatch_count,
                     byte_reports_q.size());
            $display("** gzip_member_header_parser: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d reports pending", cycle_count,
                 byte_reports_q.size());
        $display("** gzip_member_header_parser: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/gmhp_pkg.sv
rtl/gmhp_parse_core.sv
rtl/gmhp_out_stage.sv
rtl/gzip_member_header_parser.sv
dv/tb_gzip_member_header_parser.sv
